// File: sv/assert_macros.svh
// Assertion macros used by the top level of the address generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// File: sv/mda_pkg.sv
// Package with the shared types and constants of the address generator.
package mda_pkg;

  localparam int MaxDimsDef    = 10;
  localparam int QueueDepthDef = 2;

  localparam int DimW   = 4;
  localparam int BoundW = 16;
  localparam int ExtW   = 17;
  localparam int AddrW  = 32;
  localparam int SizeW  = 16;
  localparam int TdataW = 56;
  localparam int PaddrW = 4;

  typedef enum logic {
    CMD_BOUNDS = 1'b0,
    CMD_INDEX  = 1'b1
  } cmd_e;

  typedef enum logic [PaddrW-1:0] {
    ADDR_BASE  = 4'h0,
    ADDR_ESIZE = 4'h4,
    ADDR_DIMS  = 4'h8
  } reg_addr_e;

  // One classified index transaction, handed from the front to the back.
  typedef struct packed {
    logic             dim_ok;   // dimension in use: the accumulator is updated
    logic             restart;  // first dimension: start from zero
    logic             last;     // final index of the query
    logic [AddrW-1:0] extent;   // extent, widened to 32 bits, negative above 65536
    logic [AddrW-1:0] diff;     // index minus lower bound
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef struct packed {
    logic idle;
    logic acc_zero;
  } back_status_t;

endpackage

// File: sv/mda_front.sv
// Front end: accepts transactions, keeps the bounds tables and classifies indices.
module mda_front #(
  parameter int MAX_DIMS = mda_pkg::MaxDimsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        in_cmd_i,
  input  logic [mda_pkg::DimW-1:0]    in_dim_i,
  input  logic [mda_pkg::BoundW-1:0]  in_lower_i,
  input  logic [mda_pkg::BoundW-1:0]  in_upper_i,
  input  logic [mda_pkg::BoundW-1:0]  in_index_i,
  input  logic                        in_last_i,
  input  logic [mda_pkg::DimW-1:0]    dims_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output mda_pkg::entry_t             push_data_o
);
  import mda_pkg::*;

  localparam int IdxW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam logic [DimW:0] MaxDimsV = (DimW+1)'(MAX_DIMS);

  logic [BoundW-1:0] lower_q [MAX_DIMS];
  logic [ExtW-1:0]   extent_q [MAX_DIMS];

  logic [DimW-1:0]   dim_m1;
  logic [IdxW-1:0]   tbl_idx;
  logic              in_table;
  logic              accept;
  logic [ExtW-1:0]   new_extent;
  logic [BoundW-1:0] rd_lower;
  logic [ExtW-1:0]   rd_extent;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i && push_ready_i;
  assign dim_m1     = in_dim_i - DimW'(1);
  assign tbl_idx    = IdxW'(dim_m1);
  assign in_table   = (in_dim_i != '0) && ({1'b0, in_dim_i} <= MaxDimsV);
  assign new_extent = {in_upper_i[BoundW-1], in_upper_i}
                    - {in_lower_i[BoundW-1], in_lower_i} + ExtW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        lower_q[i]  <= '0;
        extent_q[i] <= '0;
      end
    end else if (accept && (in_cmd_i == CMD_BOUNDS) && in_table) begin
      lower_q[tbl_idx]  <= in_lower_i;
      extent_q[tbl_idx] <= new_extent;
    end
  end

  always_comb begin
    rd_lower  = '0;
    rd_extent = '0;
    if (in_table) begin
      rd_lower  = lower_q[tbl_idx];
      rd_extent = extent_q[tbl_idx];
    end
  end

  always_comb begin
    push_valid_o         = in_valid_i && (in_cmd_i == CMD_INDEX);
    push_data_o.dim_ok   = in_table && (in_dim_i <= dims_i);
    push_data_o.restart  = (in_dim_i == DimW'(1));
    push_data_o.last     = in_last_i;
    // Patterns above 65536 hold a negative extent.
    if (rd_extent > ExtW'(65536)) begin
      push_data_o.extent = {{(AddrW-ExtW){1'b1}}, rd_extent};
    end else begin
      push_data_o.extent = {{(AddrW-ExtW){1'b0}}, rd_extent};
    end
    push_data_o.diff = {{(AddrW-BoundW){in_index_i[BoundW-1]}}, in_index_i}
                     - {{(AddrW-BoundW){rd_lower[BoundW-1]}}, rd_lower};
  end

endmodule

// File: sv/mda_fifo.sv
// Short queue between the front end and the arithmetic back end.
module mda_fifo #(
  parameter int DEPTH = mda_pkg::QueueDepthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  mda_pkg::entry_t       push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output mda_pkg::entry_t       pop_data_o,
  output mda_pkg::fifo_status_t status_o
);
  import mda_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  entry_t          mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push, do_pop;

  assign push_ready_o   = (count_q != FullCnt);
  assign pop_valid_o    = (count_q != '0);
  assign pop_data_o     = mem_q[rd_ptr_q];
  assign do_push        = push_valid_i && push_ready_o;
  assign do_pop         = pop_valid_o && pop_ready_i;
  assign status_o.full  = !push_ready_o;
  assign status_o.empty = !pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/mda_back.sv
// Back end: Horner multiply-accumulate, final scaling and the output register.
module mda_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       pop_valid_i,
  output logic                       pop_ready_o,
  input  mda_pkg::entry_t            pop_data_i,
  input  logic [mda_pkg::AddrW-1:0]  base_i,
  input  logic [mda_pkg::SizeW-1:0]  esize_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [mda_pkg::AddrW-1:0]  out_data_o,
  output mda_pkg::back_status_t      status_o
);
  import mda_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MAC   = 5'b00010,
    S_ADD   = 5'b00100,
    S_SCALE = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  entry_t           ent_q, ent_d;
  logic [AddrW-1:0] prod_q, prod_d;
  logic [AddrW-1:0] acc_q, acc_d;
  logic             out_valid_q, out_valid_d;
  logic [AddrW-1:0] out_data_q, out_data_d;
  logic [AddrW-1:0] acc_eff;
  logic             out_free;

  assign pop_ready_o       = (state_q == S_IDLE);
  assign acc_eff           = ent_q.restart ? '0 : acc_q;
  assign out_free          = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_data_o        = out_data_q;
  assign status_o.idle     = (state_q == S_IDLE);
  assign status_o.acc_zero = (acc_q == '0);

  always_comb begin
    state_d     = state_q;
    ent_d       = ent_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          ent_d = pop_data_i;
          if (pop_data_i.dim_ok) begin
            state_d = S_MAC;
          end else if (pop_data_i.last) begin
            state_d = S_SCALE;
          end
        end
      end
      S_MAC: begin
        prod_d  = acc_eff * ent_q.extent;
        state_d = S_ADD;
      end
      S_ADD: begin
        acc_d   = prod_q + ent_q.diff;
        state_d = ent_q.last ? S_SCALE : S_IDLE;
      end
      S_SCALE: begin
        prod_d  = acc_q * {{(AddrW-SizeW){1'b0}}, esize_i};
        acc_d   = '0;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_data_d  = base_i + prod_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q      <= ent_d;
    prod_q     <= prod_d;
    out_data_q <= out_data_d;
  end

endmodule

// File: sv/multidim_array_address.sv
// Top level of the row-major multi-dimensional array address generator.
// Bounds transactions are handled in the front end and produce no result.
// Index transactions pass the back-end steps entry, multiply and add (an index
// of an unused dimension skips multiply and add); a final index is then scaled
// by element size and output. The back end takes the next index only when idle.
// Reset clears the bounds tables, the accumulator, the queue and the output.
`include "assert_macros.svh"

module multidim_array_address #(
  parameter int MAX_DIMS    = mda_pkg::MaxDimsDef,
  parameter int QUEUE_DEPTH = mda_pkg::QueueDepthDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata from bit 0: dim[3:0], lower_bound[19:4], upper_bound[35:20],
  // index_value[51:36], zero padding[55:52].
  input  logic [mda_pkg::TdataW-1:0]  s_axis_tdata,
  // tuser: cmd (0 sets bounds, 1 supplies an index).
  input  logic                        s_axis_tuser,
  input  logic                        s_axis_tlast,
  // Result stream; tdata: address[31:0].
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [mda_pkg::AddrW-1:0]   m_axis_tdata,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mda_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import mda_pkg::*;

  // Configuration registers. They are to change only while the block is idle (the
  // user's duty; the block does not enforce it), so the back end reads them directly.
  logic [AddrW-1:0] base_q;
  logic [SizeW-1:0] esize_q;
  logic [DimW-1:0]  dims_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= '0;
      esize_q <= SizeW'(1);
      dims_q  <= DimW'(1);
    end else if (cfg_wr) begin
      unique case (paddr)
        ADDR_BASE:  base_q  <= pwdata;
        ADDR_ESIZE: esize_q <= pwdata[SizeW-1:0];
        ADDR_DIMS:  dims_q  <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_BASE:  prdata = base_q;
      ADDR_ESIZE: prdata = {{(32-SizeW){1'b0}}, esize_q};
      ADDR_DIMS:  prdata = {{(32-DimW){1'b0}}, dims_q};
      default:    prdata = '0;
    endcase
  end

  // Front end: bounds transactions update the tables here, index transactions
  // are looked up and queued with their extent and index offset.
  logic         push_valid, push_ready;
  entry_t       push_data;
  logic         pop_valid, pop_ready;
  entry_t       pop_data;
  fifo_status_t fifo_st;
  back_status_t back_st;

  mda_front #(
    .MAX_DIMS(MAX_DIMS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (s_axis_tuser),
    .in_dim_i     (s_axis_tdata[3:0]),
    .in_lower_i   (s_axis_tdata[19:4]),
    .in_upper_i   (s_axis_tdata[35:20]),
    .in_index_i   (s_axis_tdata[51:36]),
    .in_last_i    (s_axis_tlast),
    .dims_i       (dims_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  mda_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data),
    .status_o     (fifo_st)
  );

  // Back end: a multiply per used-dimension index into a product register, then
  // the add into the accumulator; final index is scaled and offset by the base.
  mda_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .base_i      (base_q),
    .esize_i     (esize_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .status_o    (back_st)
  );

  // A full queue must hold off every input transaction.
  `ASSERT_IMP(a_full_stalls, clk_i, rst_ni, fifo_st.full, !s_axis_tready)
  // A fresh result is only shown after the accumulator has been cleared.
  `ASSERT_IMP(a_result_clears_acc, clk_i, rst_ni, $rose(m_axis_tvalid), back_st.acc_zero)
  // With nothing queued or in flight, no result can appear in the next cycle.
  `ASSERT_NXT(a_no_phantom_result, clk_i, rst_ni,
              back_st.idle && fifo_st.empty && !m_axis_tvalid, !m_axis_tvalid)

endmodule
